@@ rtl/quoted_printable_decoder_assert.svh @@
// Assertion helpers for the quoted-printable decoder.
// Each macro expects clk and arst_n in scope.
`ifndef QUOTED_PRINTABLE_DECODER_ASSERT_SVH
`define QUOTED_PRINTABLE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define QPD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qpd same-cycle check failed");

// Next-cycle implication.
`define QPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qpd next-cycle check failed");

`endif

@@ rtl/qpd_pkg.sv @@
package qpd_pkg;

	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       no_byte;
		logic       final_res;
	} out_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_EQ   = 3'b010,
		PH_HELD = 3'b100
	} phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30;
		end else if (c inside {[8'h41:8'h46]}) begin
			v = c - 8'h37;
		end else if (c inside {[8'h61:8'h66]}) begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

endpackage

@@ rtl/quoted_printable_decoder.sv @@
// Quoted-printable decoder: takes one encoded character per transaction and
// releases zero to three decoded bytes. "=" CR LF is dropped, "=" with two hex
// digits becomes one byte, any other "=" sequence is copied literally. The
// transaction flagged end_of_text closes the string: held characters are
// released, final_res marks its last result, and a lone marker with no_byte set
// is sent if nothing else comes out. Input sits in one register, the decode
// step fills a three-entry result register, which drains one result per cycle
// while out_ready is high. Rate: one character per cycle while each releases
// at most one result and out_ready is high; one that releases more holds the
// result register until all are taken and so stalls the input. A character
// goes through the input register, then the result register, to the output.
module quoted_printable_decoder
	import qpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	`include "quoted_printable_decoder_assert.svh"

	// input register
	logic       vld_s1;
	in_t        in_s1;

	// decode state
	phase_t     phase_q;
	logic [7:0] held_q;

	// result register
	logic [7:0] res_q [MAX_RES];
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       nob_q;
	logic       fin_q;

	// decode step
	logic [7:0] res_d [MAX_RES];
	logic [1:0] n_d;
	logic       nob_d;
	phase_t     phase_d;
	logic [7:0] held_d;

	logic take;
	logic last_idx;
	logic can_go;
	logic adv;

	assign out_valid = (cnt_q != 2'd0);
	assign take      = out_valid && out_ready;
	assign last_idx  = (idx_q == cnt_q - 2'd1);
	assign can_go    = !out_valid || (take && last_idx);
	assign adv       = vld_s1 && can_go;
	assign in_ready  = !vld_s1 || can_go;

	assign out_data.byte_out  = res_q[idx_q];
	assign out_data.no_byte   = nob_q;
	assign out_data.final_res = fin_q && last_idx;

	always_comb begin
		logic [7:0] c;
		logic [7:0] h;
		c       = in_s1.char_in;
		h       = held_q;
		res_d   = '{default: 8'h00};
		n_d     = 2'd0;
		nob_d   = 1'b0;
		phase_d = phase_q;
		held_d  = held_q;
		case (phase_q)
			PH_EQ: begin
				held_d  = c;
				phase_d = PH_HELD;
			end
			PH_HELD: begin
				phase_d = PH_IDLE;
				if (h == CH_CR && c == CH_LF) begin
					// soft line break: drop
				end else if (is_hex(h) && is_hex(c)) begin
					res_d[n_d] = {hex_val(h), hex_val(c)};
					n_d = n_d + 2'd1;
				end else begin
					res_d[n_d] = CH_EQ;
					n_d = n_d + 2'd1;
					if (h == CH_EQ) begin
						// held '=' opens a new escape
						held_d  = c;
						phase_d = PH_HELD;
					end else begin
						res_d[n_d] = h;
						n_d = n_d + 2'd1;
						if (c == CH_EQ) begin
							phase_d = PH_EQ;
						end else begin
							res_d[n_d] = c;
							n_d = n_d + 2'd1;
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (c == CH_EQ) begin
					phase_d = PH_EQ;
				end else begin
					res_d[n_d] = c;
					n_d = n_d + 2'd1;
				end
			end
		endcase
		if (in_s1.end_of_text) begin
			// flush held characters literally
			if (phase_d != PH_IDLE) begin
				res_d[n_d] = CH_EQ;
				n_d = n_d + 2'd1;
			end
			if (phase_d == PH_HELD) begin
				res_d[n_d] = held_d;
				n_d = n_d + 2'd1;
			end
			if (n_d == 2'd0) begin
				nob_d = 1'b1;
				n_d   = 2'd1;
			end
			phase_d = PH_IDLE;
			held_d  = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'h00;
		end else if (adv) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
			fin_q <= 1'b0;
		end else if (adv && n_d != 2'd0) begin
			cnt_q <= n_d;
			idx_q <= 2'd0;
			fin_q <= in_s1.end_of_text;
		end else if (take) begin
			if (last_idx) begin
				cnt_q <= 2'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_d != 2'd0) begin
			res_q <= res_d;
			nob_q <= nob_d;
		end
	end

	`QPD_ASSERT_IMPL(a_idx_in_range, out_valid, idx_q < cnt_q)
	`QPD_ASSERT_NEXT(a_hold_remaining, take && !last_idx, out_valid)
	`QPD_ASSERT_IMPL(a_marker_alone, out_valid && out_data.no_byte,
		out_data.byte_out == 8'h00 && out_data.final_res && cnt_q == 2'd1)
	`QPD_ASSERT_NEXT(a_eot_resets, adv && in_s1.end_of_text,
		phase_q == PH_IDLE && held_q == 8'h00)

endmodule
